### rtl/space_to_depth_address_generator_macros.svh
// Assertion macros for the space-to-depth address generator.
// Needs a clock named clk and an active-low reset named rst_n in the using module.
`ifndef SPACE_TO_DEPTH_ADDRESS_GENERATOR_MACROS_SVH
`define SPACE_TO_DEPTH_ADDRESS_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define S2D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that a condition never holds outside reset.
`define S2D_ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define S2D_ASSERT(label, prop, msg)
`define S2D_ASSERT_NEVER(label, cond, msg)
`endif
`endif

### rtl/s2d_pkg.sv
// Shared types, constants and helper functions of the space-to-depth address generator.
// No dependencies.
`default_nettype none

package s2d_pkg;

  localparam int DIM_W    = 11;
  localparam int CHAN_W   = 13;
  localparam int STRIDE_W = 4;
  localparam int COL_W    = 10;
  localparam int ROW_W    = 10;
  localparam int CCNT_W   = 12;
  localparam int IDX_W    = 32;
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [DIM_W-1:0]    MAX_DIM      = 11'd1024;
  localparam logic [CHAN_W-1:0]   MAX_CHANNELS = 13'd4096;
  localparam logic [STRIDE_W-1:0] MAX_STRIDE   = 4'd8;

  // Divider: dividend and divisor width, one quotient bit per cycle
  localparam int DIV_W     = 13;
  localparam int DIV_CNT_W = 4;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 4'd13;

  // Register indexes
  localparam logic [1:0] REG_WIDTH    = 2'd0;
  localparam logic [1:0] REG_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_CHANNELS = 2'd2;
  localparam logic [1:0] REG_STRIDE   = 2'd3;

  // Divider operand selects
  localparam logic [1:0] DIV_SEL_GROUPS = 2'd0;  // channels / stride^2
  localparam logic [1:0] DIV_SEL_CHAN   = 2'd1;  // channel / groups
  localparam logic [1:0] DIV_SEL_PHASE  = 2'd2;  // phase / stride

  // Multiply-add steps
  localparam logic [2:0] MAC_DST_INNER = 3'd0;  // h*chan + row
  localparam logic [2:0] MAC_DST       = 3'd1;  // w*t + col
  localparam logic [2:0] MAC_SRC_ROW   = 3'd2;  // h*group + row
  localparam logic [2:0] MAC_SRC_PLANE = 3'd3;  // s*t + hoff
  localparam logic [2:0] MAC_SRC_COL   = 3'd4;  // w*t + col
  localparam logic [2:0] MAC_SRC       = 3'd5;  // s*t + woff
  localparam logic [2:0] MAC_FIRST     = MAC_DST_INNER;
  localparam logic [2:0] MAC_LAST      = MAC_SRC;

  typedef struct packed {
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [CHAN_W-1:0]   channels;
    logic [STRIDE_W-1:0] stride;
  } cfg_t;

  typedef struct packed {
    logic       accept;
    logic       div_start;
    logic [1:0] div_sel;
    logic       latch_chan;
    logic       latch_phase;
    logic       mac_en;
    logic [2:0] mac_step;
    logic       emit;
  } dp_cmd_t;

  typedef struct packed {
    logic cfg_err;
    logic div_busy;
    logic out_free;
  } dp_sts_t;

  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
    return (v == '0) ? DIM_W'(1) : ((v > MAX_DIM) ? MAX_DIM : v);
  endfunction

  function automatic logic [CHAN_W-1:0] eff_chan(input logic [CHAN_W-1:0] v);
    return (v == '0) ? CHAN_W'(1) : ((v > MAX_CHANNELS) ? MAX_CHANNELS : v);
  endfunction

  function automatic logic [STRIDE_W-1:0] eff_stride(input logic [STRIDE_W-1:0] v);
    return (v == '0) ? STRIDE_W'(1) : ((v > MAX_STRIDE) ? MAX_STRIDE : v);
  endfunction

endpackage

`default_nettype wire

### rtl/s2d_stream_if.sv
// Valid/ready stream interfaces for the input beats and the result beats.
// No dependencies besides the package widths.
`default_nettype none

interface s2d_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface s2d_out_if;
  logic                     valid;
  logic                     ready;
  logic [s2d_pkg::IDX_W-1:0] dest_index;
  logic [s2d_pkg::IDX_W-1:0] src_index;
  logic                     last;
  logic                     config_error;

  modport source (output valid, output dest_index, output src_index, output last,
                  output config_error, input ready);
  modport sink   (input valid, input dest_index, input src_index, input last,
                  input config_error, output ready);
endinterface

`default_nettype wire

### rtl/s2d_regs.sv
// APB-style configuration registers: width, height, channels, stride.
// Depends on s2d_pkg.
`default_nettype none

module s2d_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [s2d_pkg::PADDR_W-1:0]   paddr,
  input  logic [s2d_pkg::PDATA_W-1:0]   pwdata,
  output logic [s2d_pkg::PDATA_W-1:0]   prdata,
  output s2d_pkg::cfg_t                 cfg
);

  logic [s2d_pkg::DIM_W-1:0]    width_r;
  logic [s2d_pkg::DIM_W-1:0]    height_r;
  logic [s2d_pkg::CHAN_W-1:0]   channels_r;
  logic [s2d_pkg::STRIDE_W-1:0] stride_r;
  logic [1:0]                   reg_idx;

  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= s2d_pkg::DIM_W'(1);
      height_r   <= s2d_pkg::DIM_W'(1);
      channels_r <= s2d_pkg::CHAN_W'(1);
      stride_r   <= s2d_pkg::STRIDE_W'(1);
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        s2d_pkg::REG_WIDTH:    width_r    <= pwdata[s2d_pkg::DIM_W-1:0];
        s2d_pkg::REG_HEIGHT:   height_r   <= pwdata[s2d_pkg::DIM_W-1:0];
        s2d_pkg::REG_CHANNELS: channels_r <= pwdata[s2d_pkg::CHAN_W-1:0];
        s2d_pkg::REG_STRIDE:   stride_r   <= pwdata[s2d_pkg::STRIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      s2d_pkg::REG_WIDTH:    prdata = s2d_pkg::PDATA_W'(width_r);
      s2d_pkg::REG_HEIGHT:   prdata = s2d_pkg::PDATA_W'(height_r);
      s2d_pkg::REG_CHANNELS: prdata = s2d_pkg::PDATA_W'(channels_r);
      s2d_pkg::REG_STRIDE:   prdata = s2d_pkg::PDATA_W'(stride_r);
      default:               prdata = '0;
    endcase
  end

  assign cfg.width    = width_r;
  assign cfg.height   = height_r;
  assign cfg.channels = channels_r;
  assign cfg.stride   = stride_r;

endmodule

`default_nettype wire

### rtl/s2d_divider.sv
// Restoring divider, one quotient bit per cycle, 13-bit operands.
// Depends on s2d_pkg and the assertion macro header.
`default_nettype none
`include "space_to_depth_address_generator_macros.svh"

module s2d_divider (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [s2d_pkg::DIV_W-1:0] dividend,
  input  logic [s2d_pkg::DIV_W-1:0] divisor,
  output logic                      busy,
  output logic [s2d_pkg::DIV_W-1:0] quotient,
  output logic [s2d_pkg::DIV_W-1:0] remainder
);

  logic [s2d_pkg::DIV_CNT_W-1:0] cnt_r;
  logic [s2d_pkg::DIV_W-1:0]     rem_r;
  logic [s2d_pkg::DIV_W-1:0]     quo_r;
  logic [s2d_pkg::DIV_W-1:0]     dvs_r;
  logic [s2d_pkg::DIV_W:0]       shifted;
  logic [s2d_pkg::DIV_W+1:0]     diff;
  logic                          fits;

  // Shift in the next dividend bit and try a subtract
  assign shifted = {rem_r, quo_r[s2d_pkg::DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dvs_r};
  assign fits    = !diff[s2d_pkg::DIV_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= s2d_pkg::DIV_STEPS;
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - s2d_pkg::DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r <= '0;
      quo_r <= '0;
      dvs_r <= '0;
    end else if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[s2d_pkg::DIV_W-1:0] : shifted[s2d_pkg::DIV_W-1:0];
      quo_r <= {quo_r[s2d_pkg::DIV_W-2:0], fits};
    end
  end

  assign busy      = (cnt_r != '0);
  assign quotient  = quo_r;
  assign remainder = rem_r;

  `S2D_ASSERT(a_div_hold_idle, !busy && !start |=> $stable(quo_r) && $stable(rem_r),
              "divider result moved while idle")

endmodule

`default_nettype wire

### rtl/s2d_datapath.sv
// Datapath: element counters, shared divider, multiply-add unit, result register.
// Depends on s2d_pkg, s2d_divider and the assertion macro header.
`default_nettype none
`include "space_to_depth_address_generator_macros.svh"

module s2d_datapath (
  input  logic                      clk,
  input  logic                      rst_n,
  input  s2d_pkg::cfg_t             cfg,
  input  s2d_pkg::dp_cmd_t          cmd,
  output s2d_pkg::dp_sts_t          sts,
  input  logic                      in_restart,
  input  logic                      out_ready,
  output logic                      out_valid,
  output logic [s2d_pkg::IDX_W-1:0] out_dest_index,
  output logic [s2d_pkg::IDX_W-1:0] out_src_index,
  output logic                      out_last,
  output logic                      out_config_error
);

  logic [s2d_pkg::DIM_W-1:0]    w;
  logic [s2d_pkg::DIM_W-1:0]    h;
  logic [s2d_pkg::CHAN_W-1:0]   c;
  logic [s2d_pkg::STRIDE_W-1:0] s;
  logic [7:0]                   s_sq;
  logic                         cfg_err;

  logic [s2d_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [s2d_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [s2d_pkg::CCNT_W-1:0] chan_r, chan_nxt;
  logic                       col_end, row_end, chan_end, is_last;

  logic [s2d_pkg::CCNT_W-1:0] group_r;
  logic [s2d_pkg::CCNT_W-1:0] hoff_r;
  logic [2:0]                 woff_r;

  logic [s2d_pkg::DIV_W-1:0] div_a, div_b, div_q, div_rem;
  logic                      div_busy;

  logic [s2d_pkg::IDX_W-1:0]  mac_a;
  logic [s2d_pkg::DIM_W-1:0]  mac_b;
  logic [s2d_pkg::DIV_W-1:0]  mac_c;
  logic [s2d_pkg::IDX_W-1:0]  mac_nxt;
  logic [s2d_pkg::IDX_W-1:0]  t_r, dst_r, src_r;

  logic                      out_valid_r;
  logic [s2d_pkg::IDX_W-1:0] out_dst_r, out_src_r;
  logic                      out_last_r, out_err_r;

  assign w    = s2d_pkg::eff_dim(cfg.width);
  assign h    = s2d_pkg::eff_dim(cfg.height);
  assign c    = s2d_pkg::eff_chan(cfg.channels);
  assign s    = s2d_pkg::eff_stride(cfg.stride);
  assign s_sq = 8'(s) * 8'(s);
  assign cfg_err = (c < s2d_pkg::CHAN_W'(s_sq));

  // Counter wrap tests: at or beyond the final value
  assign col_end  = ((s2d_pkg::DIM_W'(col_r) + s2d_pkg::DIM_W'(1)) >= w);
  assign row_end  = ((s2d_pkg::DIM_W'(row_r) + s2d_pkg::DIM_W'(1)) >= h);
  assign chan_end = ((s2d_pkg::CHAN_W'(chan_r) + s2d_pkg::CHAN_W'(1)) >= c);
  assign is_last  = col_end && row_end && chan_end;

  always_comb begin
    col_nxt  = col_r;
    row_nxt  = row_r;
    chan_nxt = chan_r;
    if (cmd.accept && in_restart) begin
      col_nxt  = '0;
      row_nxt  = '0;
      chan_nxt = '0;
    end else if (cmd.emit && !cfg_err) begin
      if (col_end) begin
        col_nxt = '0;
        if (row_end) begin
          row_nxt  = '0;
          chan_nxt = chan_end ? '0 : chan_r + s2d_pkg::CCNT_W'(1);
        end else begin
          row_nxt = row_r + s2d_pkg::ROW_W'(1);
        end
      end else begin
        col_nxt = col_r + s2d_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      chan_r <= '0;
    end else begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      chan_r <= chan_nxt;
    end
  end

  // Divider operands: the quotient of one pass feeds the next
  always_comb begin
    case (cmd.div_sel)
      s2d_pkg::DIV_SEL_GROUPS: begin
        div_a = c;
        div_b = s2d_pkg::DIV_W'(s_sq);
      end
      s2d_pkg::DIV_SEL_CHAN: begin
        div_a = s2d_pkg::DIV_W'(chan_r);
        div_b = div_q;
      end
      s2d_pkg::DIV_SEL_PHASE: begin
        div_a = div_q;
        div_b = s2d_pkg::DIV_W'(s);
      end
      default: begin
        div_a = c;
        div_b = s2d_pkg::DIV_W'(s_sq);
      end
    endcase
  end

  s2d_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .quotient  (div_q),
    .remainder (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch_chan) begin
      group_r <= div_rem[s2d_pkg::CCNT_W-1:0];
    end
    if (cmd.latch_phase) begin
      hoff_r <= div_q[s2d_pkg::CCNT_W-1:0];
      woff_r <= div_rem[2:0];
    end
  end

  // Multiply-add operands per step, all modulo 2^32
  always_comb begin
    case (cmd.mac_step)
      s2d_pkg::MAC_DST_INNER: begin
        mac_a = s2d_pkg::IDX_W'(chan_r);
        mac_b = h;
        mac_c = s2d_pkg::DIV_W'(row_r);
      end
      s2d_pkg::MAC_DST: begin
        mac_a = t_r;
        mac_b = w;
        mac_c = s2d_pkg::DIV_W'(col_r);
      end
      s2d_pkg::MAC_SRC_ROW: begin
        mac_a = s2d_pkg::IDX_W'(group_r);
        mac_b = h;
        mac_c = s2d_pkg::DIV_W'(row_r);
      end
      s2d_pkg::MAC_SRC_PLANE: begin
        mac_a = t_r;
        mac_b = s2d_pkg::DIM_W'(s);
        mac_c = s2d_pkg::DIV_W'(hoff_r);
      end
      s2d_pkg::MAC_SRC_COL: begin
        mac_a = t_r;
        mac_b = w;
        mac_c = s2d_pkg::DIV_W'(col_r);
      end
      s2d_pkg::MAC_SRC: begin
        mac_a = t_r;
        mac_b = s2d_pkg::DIM_W'(s);
        mac_c = s2d_pkg::DIV_W'(woff_r);
      end
      default: begin
        mac_a = t_r;
        mac_b = w;
        mac_c = '0;
      end
    endcase
  end

  assign mac_nxt = mac_a * s2d_pkg::IDX_W'(mac_b) + s2d_pkg::IDX_W'(mac_c);

  always_ff @(posedge clk) begin
    if (cmd.mac_en) begin
      case (cmd.mac_step)
        s2d_pkg::MAC_DST: dst_r <= mac_nxt;
        s2d_pkg::MAC_SRC: src_r <= mac_nxt;
        default:          t_r   <= mac_nxt;
      endcase
    end
  end

  // Result register: frees the controller while the beat waits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cfg_err) begin
        out_dst_r  <= '0;
        out_src_r  <= '0;
        out_last_r <= 1'b0;
        out_err_r  <= 1'b1;
      end else begin
        out_dst_r  <= dst_r;
        out_src_r  <= src_r;
        out_last_r <= is_last;
        out_err_r  <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_dest_index   = out_dst_r;
  assign out_src_index    = out_src_r;
  assign out_last         = out_last_r;
  assign out_config_error = out_err_r;

  assign sts.cfg_err  = cfg_err;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

  `S2D_ASSERT_NEVER(a_out_overwrite, cmd.emit && out_valid_r && !out_ready,
                    "result register loaded while a beat is pending")
  `S2D_ASSERT(a_err_zero, out_valid_r && out_err_r |-> (out_dst_r == '0) &&
              (out_src_r == '0) && !out_last_r, "error beat carries nonzero fields")

endmodule

`default_nettype wire

### rtl/s2d_ctrl.sv
// Controller: sequences accept, three divider passes, six multiply-add steps and emit.
// Depends on s2d_pkg and the assertion macro header.
`default_nettype none
`include "space_to_depth_address_generator_macros.svh"

module s2d_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  s2d_pkg::dp_sts_t sts,
  output s2d_pkg::dp_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_DIV_GRP = 3'd1;
  localparam logic [2:0] ST_DIV_CHN = 3'd2;
  localparam logic [2:0] ST_DIV_PHS = 3'd3;
  localparam logic [2:0] ST_MAC     = 3'd4;
  localparam logic [2:0] ST_EMIT    = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [2:0] step_r, step_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    step_nxt  = step_r;
    in_ready  = (state_r == ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.cfg_err) begin
            state_nxt = ST_EMIT;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = s2d_pkg::DIV_SEL_GROUPS;
            state_nxt     = ST_DIV_GRP;
          end
        end
      end
      ST_DIV_GRP: begin
        if (!sts.div_busy) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = s2d_pkg::DIV_SEL_CHAN;
          state_nxt     = ST_DIV_CHN;
        end
      end
      ST_DIV_CHN: begin
        if (!sts.div_busy) begin
          cmd.latch_chan = 1'b1;
          cmd.div_start  = 1'b1;
          cmd.div_sel    = s2d_pkg::DIV_SEL_PHASE;
          state_nxt      = ST_DIV_PHS;
        end
      end
      ST_DIV_PHS: begin
        if (!sts.div_busy) begin
          cmd.latch_phase = 1'b1;
          step_nxt        = s2d_pkg::MAC_FIRST;
          state_nxt       = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd.mac_en   = 1'b1;
        cmd.mac_step = step_r;
        if (step_r == s2d_pkg::MAC_LAST) begin
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r + 3'd1;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= s2d_pkg::MAC_FIRST;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
    end
  end

  `S2D_ASSERT_NEVER(a_div_start_busy, cmd.div_start && sts.div_busy,
                    "divider restarted mid-division")
  `S2D_ASSERT(a_emit_then_idle, cmd.emit |=> in_ready,
              "controller not ready after emitting a beat")

endmodule

`default_nettype wire

### rtl/space_to_depth_address_generator.sv
// Space-to-depth address generator: one input beat yields one result beat (dest/src index).
// An input beat is taken only in idle, after the previous result has been emitted; between
// accept and result valid lie three passes of the shared bit-serial divider,
// the phase latch, six multiply-add steps and the emit, which waits for a free
// result register. With channels below stride squared an error beat is emitted instead.
// Reset (rst_n, synchronous): registers to 1, counters to zero, no result pending.
`default_nettype none

module space_to_depth_address_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  s2d_in_if.sink                      in_ch,
  s2d_out_if.source                   out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [s2d_pkg::PADDR_W-1:0] paddr,
  input  logic [s2d_pkg::PDATA_W-1:0] pwdata,
  output logic [s2d_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  s2d_pkg::cfg_t    cfg;
  s2d_pkg::dp_cmd_t cmd;
  s2d_pkg::dp_sts_t sts;

  // Zero-wait-state register port
  assign pready = 1'b1;

  // Raw register values; saturation and zero handling happen in the datapath
  s2d_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // Controller: take a beat in idle, walk the divider passes
  // (groups, channel split, phase split), then the multiply-add steps,
  // and hand the result to the output register once it is free.
  s2d_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: counters advance only when a beat is emitted, restart clears
  // them on accept; the output register holds the beat until taken, so the
  // next input beat is accepted while a result still waits.
  s2d_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg),
    .cmd              (cmd),
    .sts              (sts),
    .in_restart       (in_ch.restart),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_dest_index   (out_ch.dest_index),
    .out_src_index    (out_ch.src_index),
    .out_last         (out_ch.last),
    .out_config_error (out_ch.config_error)
  );

endmodule

`default_nettype wire
